/* hw/rtl/nfsm_pkg.sv */
`default_nettype none
package nfsm_pkg;

	// Default build values for the top-level parameters.
	localparam int PHASE_BITS_DEF        = 32;
	localparam int TABLE_ADDR_BITS_DEF   = 10;
	localparam int MAX_BLOCK_SAMPLES_DEF = 131072;

	localparam int STEP_W   = 32;
	localparam int SAMPLE_W = 8;
	localparam int TRIG_W   = 16;
	localparam int MIX_W    = 24;
	localparam int POWER_W  = 16;
	localparam int ENERGY_W = 33;
	localparam int COUNT_W  = 18;

	// round(pi/2 * 2^30)
	localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic signed [TRIG_W-1:0]   trig_t;
	typedef logic signed [MIX_W-1:0]    mix_t;
	typedef logic [POWER_W-1:0]         power_t;
	typedef logic [ENERGY_W-1:0]        energy_t;
	typedef logic [COUNT_W-1:0]         count_t;
	typedef logic [STEP_W-1:0]          step_t;

	// Accumulator control from the pipeline to the block statistics.
	typedef struct packed {
		logic load;
		logic last;
	} acc_ctl_t;

	// Quarter-wave sine in Q1.15, Taylor series through x^15 in Q30,
	// every term truncated. Evaluated at elaboration only.
	function automatic logic [TRIG_W-2:0] quarter_sine(input longint unsigned r,
			input int abits);
		longint unsigned x;
		longint unsigned x2;
		longint unsigned term;
		longint unsigned sum;
		x    = (HALF_PI_Q30 * r) >> (abits - 2);
		x2   = (x * x) >> 30;
		term = x;
		sum  = x;
		term = ((term * x2) >> 30) / 64'd6;   sum = sum - term;
		term = ((term * x2) >> 30) / 64'd20;  sum = sum + term;
		term = ((term * x2) >> 30) / 64'd42;  sum = sum - term;
		term = ((term * x2) >> 30) / 64'd72;  sum = sum + term;
		term = ((term * x2) >> 30) / 64'd110; sum = sum - term;
		term = ((term * x2) >> 30) / 64'd156; sum = sum + term;
		term = ((term * x2) >> 30) / 64'd210; sum = sum - term;
		sum = (sum + 64'd16384) >> 15;
		if (sum > 64'd32767) begin
			sum = 64'd32767;
		end
		return sum[TRIG_W-2:0];
	endfunction

endpackage
`default_nettype wire

/* hw/rtl/nfsm_phase.sv */
`default_nettype none
module nfsm_phase #(
	parameter int PHASE_BITS      = nfsm_pkg::PHASE_BITS_DEF,
	parameter int TABLE_ADDR_BITS = nfsm_pkg::TABLE_ADDR_BITS_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cfg_wr,
	input  wire nfsm_pkg::step_t            cfg_step,
	input  wire logic                       advance,
	output logic [TABLE_ADDR_BITS-1:0]      addr
);

	nfsm_pkg::step_t         step_q;
	logic [PHASE_BITS-1:0]   phase_q;
	logic [PHASE_BITS-1:0]   step_al;

	// Step is aligned to the top of the accumulator.
	generate
		if (PHASE_BITS >= nfsm_pkg::STEP_W) begin : g_wide
			assign step_al = PHASE_BITS'(signed'(step_q)) << (PHASE_BITS - nfsm_pkg::STEP_W);
		end else begin : g_narrow
			assign step_al = step_q[nfsm_pkg::STEP_W-1 -: PHASE_BITS];
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q  <= '0;
			phase_q <= '0;
		end else begin
			if (cfg_wr) begin
				step_q <= cfg_step;
			end
			if (advance) begin
				phase_q <= phase_q + step_al;
			end
		end
	end

	assign addr = phase_q[PHASE_BITS-1 -: TABLE_ADDR_BITS];

	a_phase_adv: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> phase_q == $past(phase_q + step_al))
		else $error("phase did not advance by one step");

endmodule
`default_nettype wire

/* hw/rtl/nfsm_sincos.sv */
`default_nettype none
module nfsm_sincos #(
	parameter int TABLE_ADDR_BITS = nfsm_pkg::TABLE_ADDR_BITS_DEF
) (
	input  wire logic [TABLE_ADDR_BITS-1:0] addr,
	output nfsm_pkg::trig_t                 sin_val,
	output nfsm_pkg::trig_t                 cos_val
);

	localparam int QUARTER = 1 << (TABLE_ADDR_BITS - 2);
	localparam int IDX_W   = TABLE_ADDR_BITS - 1;
	localparam int MAG_W   = nfsm_pkg::TRIG_W - 1;

	logic [MAG_W-1:0]           qsin [0:QUARTER];
	logic [TABLE_ADDR_BITS-1:0] cos_addr;
	logic [IDX_W-1:0]           sin_idx;
	logic [IDX_W-1:0]           cos_idx;
	nfsm_pkg::trig_t            sin_mag;
	nfsm_pkg::trig_t            cos_mag;

	generate
		for (genvar g = 0; g <= QUARTER; g++) begin : g_tab
			assign qsin[g] = nfsm_pkg::quarter_sine(longint'(g), TABLE_ADDR_BITS);
		end
	endgenerate

	// cos(a) = sin(a + quarter turn)
	assign cos_addr = addr + TABLE_ADDR_BITS'(QUARTER);

	always_comb begin
		// odd quadrants read the table mirrored, the lower half-turn is negated
		sin_idx = addr[TABLE_ADDR_BITS-2] ?
			IDX_W'(QUARTER) - IDX_W'(addr[TABLE_ADDR_BITS-3:0]) :
			IDX_W'(addr[TABLE_ADDR_BITS-3:0]);
		cos_idx = cos_addr[TABLE_ADDR_BITS-2] ?
			IDX_W'(QUARTER) - IDX_W'(cos_addr[TABLE_ADDR_BITS-3:0]) :
			IDX_W'(cos_addr[TABLE_ADDR_BITS-3:0]);
		sin_mag = {1'b0, qsin[sin_idx]};
		cos_mag = {1'b0, qsin[cos_idx]};
		sin_val = addr[TABLE_ADDR_BITS-1] ? -sin_mag : sin_mag;
		cos_val = cos_addr[TABLE_ADDR_BITS-1] ? -cos_mag : cos_mag;
	end

endmodule
`default_nettype wire

/* hw/rtl/nfsm_rotate.sv */
`default_nettype none
module nfsm_rotate (
	input  wire nfsm_pkg::sample_t i_val,
	input  wire nfsm_pkg::sample_t q_val,
	input  wire nfsm_pkg::trig_t   sin_val,
	input  wire nfsm_pkg::trig_t   cos_val,
	output nfsm_pkg::mix_t         mixed_i,
	output nfsm_pkg::mix_t         mixed_q
);

	localparam int W = nfsm_pkg::MIX_W + 1;

	logic signed [W-1:0] mi_w;
	logic signed [W-1:0] mq_w;

	// (i + jq) * (cos + j sin)
	assign mi_w = W'(i_val) * W'(cos_val) - W'(q_val) * W'(sin_val);
	assign mq_w = W'(i_val) * W'(sin_val) + W'(q_val) * W'(cos_val);

	assign mixed_i = mi_w[nfsm_pkg::MIX_W-1:0];
	assign mixed_q = mq_w[nfsm_pkg::MIX_W-1:0];

endmodule
`default_nettype wire

/* hw/rtl/nfsm_accum.sv */
`default_nettype none
module nfsm_accum #(
	parameter int MAX_BLOCK_SAMPLES = nfsm_pkg::MAX_BLOCK_SAMPLES_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire nfsm_pkg::acc_ctl_t ctl,
	input  wire nfsm_pkg::power_t   power,
	output nfsm_pkg::energy_t       energy_new,
	output nfsm_pkg::count_t        count_new
);

	localparam longint COUNT_FIELD_MAX = (64'd1 << nfsm_pkg::COUNT_W) - 64'd1;
	localparam longint CMAX_L = (longint'(MAX_BLOCK_SAMPLES) < COUNT_FIELD_MAX) ?
		longint'(MAX_BLOCK_SAMPLES) : COUNT_FIELD_MAX;
	localparam nfsm_pkg::count_t CMAX = nfsm_pkg::COUNT_W'(CMAX_L);

	nfsm_pkg::energy_t               energy_q;
	nfsm_pkg::count_t                count_q;
	logic [nfsm_pkg::ENERGY_W:0]     sum_w;

	assign sum_w      = {1'b0, energy_q} + (nfsm_pkg::ENERGY_W + 1)'(power);
	assign energy_new = sum_w[nfsm_pkg::ENERGY_W] ? '1 : sum_w[nfsm_pkg::ENERGY_W-1:0];
	assign count_new  = (count_q < CMAX) ? count_q + 1'b1 : count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			energy_q <= '0;
			count_q  <= '0;
		end else if (ctl.load) begin
			energy_q <= ctl.last ? '0 : energy_new;
			count_q  <= ctl.last ? '0 : count_new;
		end
	end

	a_block_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.load && ctl.last) |=> (count_q == '0 && energy_q == '0))
		else $error("block statistics not cleared after last word");

endmodule
`default_nettype wire

/* hw/rtl/nco_frequency_shift_mixer_unit.sv */
`default_nettype none
// Channel    Dir  Handshake                  Content
// s_axis     in   s_axis_tvalid/tready       i_sample, q_sample; tlast = block_last
// m_axis     out  m_axis_tvalid/tready       mixed_i, mixed_q, energy_sum, sample_count;
//                                            tlast = last_out
// cfg        in   cfg_valid/cfg_ready        phase_step (signed, turns * 2^32)
//
// One word per clock sustained while m_axis_tready stays high. Stages: input
// register (samples + oscillator address), sin/cos table lookup and i^2+q^2,
// then rotation multiply and block statistics.
// Each stage takes a new word whenever it is empty or the one after it moves,
// so bubbles collapse and input keeps flowing while a result waits.
// Reset clears the phase, the step register and the block statistics.
// cfg_ready is always high; writes are meant for idle periods.
module nco_frequency_shift_mixer_unit #(
	parameter int PHASE_BITS        = nfsm_pkg::PHASE_BITS_DEF,
	parameter int TABLE_ADDR_BITS   = nfsm_pkg::TABLE_ADDR_BITS_DEF,
	parameter int MAX_BLOCK_SAMPLES = nfsm_pkg::MAX_BLOCK_SAMPLES_DEF
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	// input samples
	input  wire logic         s_axis_tvalid,
	output logic              s_axis_tready,
	input  wire logic [15:0]  s_axis_tdata,   // [7:0] i_sample, [15:8] q_sample
	input  wire logic         s_axis_tlast,   // block_last
	// mixed output
	output logic              m_axis_tvalid,
	input  wire logic         m_axis_tready,
	output logic [103:0]      m_axis_tdata,   // [23:0] mixed_i, [47:24] mixed_q,
	                                          // [80:48] energy_sum, [98:81] sample_count,
	                                          // [103:99] zero
	output logic              m_axis_tlast,   // last_out
	// oscillator step register
	input  wire logic         cfg_valid,
	output logic              cfg_ready,
	input  wire logic [31:0]  cfg_data        // phase_step
);

	// stage enables, back to front
	logic en_o;
	logic en_2;
	logic en_1;
	logic s_acc;

	// stage 1: accepted word
	logic                        v_s1;
	nfsm_pkg::sample_t           i_s1;
	nfsm_pkg::sample_t           q_s1;
	logic                        last_s1;
	logic [TABLE_ADDR_BITS-1:0]  addr_s1;

	// stage 2: oscillator value and sample power
	logic                        v_s2;
	nfsm_pkg::sample_t           i_s2;
	nfsm_pkg::sample_t           q_s2;
	logic                        last_s2;
	nfsm_pkg::trig_t             sin_s2;
	nfsm_pkg::trig_t             cos_s2;
	nfsm_pkg::power_t            power_s2;

	// output register
	logic                        vo_q;
	nfsm_pkg::mix_t              mi_q;
	nfsm_pkg::mix_t              mq_q;
	nfsm_pkg::energy_t           energy_q;
	nfsm_pkg::count_t            count_q;
	logic                        last_q;

	logic [TABLE_ADDR_BITS-1:0]  phase_addr;
	nfsm_pkg::trig_t             sin_w;
	nfsm_pkg::trig_t             cos_w;
	logic signed [16:0]          power_w;
	nfsm_pkg::mix_t              mi_w;
	nfsm_pkg::mix_t              mq_w;
	nfsm_pkg::energy_t           energy_w;
	nfsm_pkg::count_t            count_w;
	nfsm_pkg::acc_ctl_t          acc_ctl;

	assign en_o          = !vo_q || m_axis_tready;
	assign en_2          = !v_s2 || en_o;
	assign en_1          = !v_s1 || en_2;
	assign s_axis_tready = en_1;
	assign s_acc         = s_axis_tvalid && en_1;
	assign cfg_ready     = 1'b1;

	// The current phase addresses the table for this word; phase then steps.
	nfsm_phase #(
		.PHASE_BITS      (PHASE_BITS),
		.TABLE_ADDR_BITS (TABLE_ADDR_BITS)
	) u_phase (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_wr   (cfg_valid),
		.cfg_step (cfg_data),
		.advance  (s_acc),
		.addr     (phase_addr)
	);

	nfsm_sincos #(
		.TABLE_ADDR_BITS (TABLE_ADDR_BITS)
	) u_sincos (
		.addr    (addr_s1),
		.sin_val (sin_w),
		.cos_val (cos_w)
	);

	nfsm_rotate u_rotate (
		.i_val   (i_s2),
		.q_val   (q_s2),
		.sin_val (sin_s2),
		.cos_val (cos_s2),
		.mixed_i (mi_w),
		.mixed_q (mq_w)
	);

	assign acc_ctl.load = en_o && v_s2;
	assign acc_ctl.last = last_s2;

	nfsm_accum #(
		.MAX_BLOCK_SAMPLES (MAX_BLOCK_SAMPLES)
	) u_accum (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (acc_ctl),
		.power      (power_s2),
		.energy_new (energy_w),
		.count_new  (count_w)
	);

	// i^2 + q^2 tops out at 32768, which fits 16 bits unsigned
	assign power_w = 17'(i_s1) * 17'(i_s1) + 17'(q_s1) * 17'(q_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			vo_q <= 1'b0;
		end else begin
			if (en_1) begin
				v_s1 <= s_axis_tvalid;
			end
			if (en_2) begin
				v_s2 <= v_s1;
			end
			if (en_o) begin
				vo_q <= v_s2;
			end
		end
	end

	// payload, no reset
	always_ff @(posedge clk) begin
		if (s_acc) begin
			i_s1    <= s_axis_tdata[7:0];
			q_s1    <= s_axis_tdata[15:8];
			last_s1 <= s_axis_tlast;
			addr_s1 <= phase_addr;
		end
		if (en_2 && v_s1) begin
			i_s2     <= i_s1;
			q_s2     <= q_s1;
			last_s2  <= last_s1;
			sin_s2   <= sin_w;
			cos_s2   <= cos_w;
			power_s2 <= power_w[nfsm_pkg::POWER_W-1:0];
		end
		if (acc_ctl.load) begin
			mi_q     <= mi_w;
			mq_q     <= mq_w;
			energy_q <= energy_w;
			count_q  <= count_w;
			last_q   <= last_s2;
		end
	end

	assign m_axis_tvalid = vo_q;
	assign m_axis_tlast  = last_q;
	assign m_axis_tdata  = {5'b0, count_q, energy_q, mq_q, mi_q};

	a_count_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		vo_q |-> count_q != '0)
		else $error("output word with zero sample count");

	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && v_s2 && vo_q && !m_axis_tready) |-> !s_axis_tready)
		else $error("input taken while pipeline full and stalled");

endmodule
`default_nettype wire

/* sim/testbench.sv */
`timescale 1ns / 1ps
module testbench;

	localparam int TAB_BITS = nfsm_pkg::TABLE_ADDR_BITS_DEF;
	localparam int TAB_SIZE = 1 << TAB_BITS;
	localparam int QUARTER  = TAB_SIZE / 4;
	// sample count holds at the block limit or the field maximum, whichever is lower
	localparam int unsigned COUNT_CAP = (nfsm_pkg::MAX_BLOCK_SAMPLES_DEF < 262143) ?
		nfsm_pkg::MAX_BLOCK_SAMPLES_DEF : 262143;
	localparam longint unsigned ENERGY_CAP = (64'd1 << nfsm_pkg::ENERGY_W) - 64'd1;
	// pipeline is 3 deep; a few spare cycles before touching the step register
	localparam int SETTLE = 8;
	// full-scale words sent with no idling on either side
	localparam int LONG_BLOCK = 40;
	localparam int REPORT_MAX = 10;

	// one output word, split into its fields
	typedef struct packed {
		nfsm_pkg::mix_t    mixed_i;
		nfsm_pkg::mix_t    mixed_q;
		nfsm_pkg::energy_t energy;
		nfsm_pkg::count_t  count;
		logic              last;
	} mixed_word_t;

	// NCO mixer model plus the queue of words still owed by the block
	class mixer_scoreboard;
		int              sine_lut[TAB_SIZE];
		logic [31:0]     phase;
		logic [31:0]     step;
		longint unsigned energy;
		int unsigned     count;
		mixed_word_t     owed_words[$];
		int              mismatches;
		int              words_seen;

		function new();
			longint unsigned x, x2, term, sum, n;
			int quad, r;
			// quarter sine by truncated Taylor series in Q30, other quadrants by symmetry
			for (int a = 0; a < TAB_SIZE; a++) begin
				quad = a / QUARTER;
				r    = a % QUARTER;
				if (quad == 1 || quad == 3) begin
					r = QUARTER - r;
				end
				x    = (nfsm_pkg::HALF_PI_Q30 * longint'(r)) >> (TAB_BITS - 2);
				x2   = (x * x) >> 30;
				term = x;
				sum  = x;
				for (n = 1; n <= 7; n++) begin
					term = ((term * x2) >> 30) / ((2 * n) * (2 * n + 1));
					sum  = n[0] ? sum - term : sum + term;
				end
				sum = (sum + 64'd16384) >> 15;
				if (sum > 64'd32767) begin
					sum = 64'd32767;
				end
				sine_lut[a] = (quad >= 2) ? -int'(sum) : int'(sum);
			end
			phase      = '0;
			step       = '0;
			energy     = 0;
			count      = 0;
			mismatches = 0;
			words_seen = 0;
		endfunction

		function int pending();
			return owed_words.size();
		endfunction

		// accepted input word: rotate by the current phase, then advance the NCO
		function void note_sample(nfsm_pkg::sample_t i, nfsm_pkg::sample_t q, logic last);
			logic [TAB_BITS-1:0] addr;
			int sn, cs, mi, mq;
			mixed_word_t w;
			addr = phase[31 -: TAB_BITS];
			sn   = sine_lut[addr];
			cs   = sine_lut[(int'(addr) + QUARTER) % TAB_SIZE];
			mi   = i * cs - q * sn;
			mq   = i * sn + q * cs;
			energy = energy + longint'(int'(i) * int'(i) + int'(q) * int'(q));
			if (energy > ENERGY_CAP) begin
				energy = ENERGY_CAP;
			end
			if (count < COUNT_CAP) begin
				count++;
			end
			w.mixed_i = mi[23:0];
			w.mixed_q = mq[23:0];
			w.energy  = energy[nfsm_pkg::ENERGY_W-1:0];
			w.count   = count[nfsm_pkg::COUNT_W-1:0];
			w.last    = last;
			owed_words.push_back(w);
			phase = phase + step;
			if (last) begin
				energy = 0;
				count  = 0;
			end
		endfunction

		function void check_word(logic [103:0] data, logic last);
			mixed_word_t got, want;
			got.mixed_i = data[23:0];
			got.mixed_q = data[47:24];
			got.energy  = data[80:48];
			got.count   = data[98:81];
			got.last    = last;
			words_seen++;
			if (owed_words.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_MAX) begin
					$display("output word %0d arrived with nothing owed: i %0d q %0d e %0d n %0d l %0b",
						words_seen, got.mixed_i, got.mixed_q, got.energy, got.count, got.last);
				end
				return;
			end
			want = owed_words.pop_front();
			if (got.mixed_i !== want.mixed_i || got.mixed_q !== want.mixed_q ||
					got.energy !== want.energy || got.count !== want.count ||
					got.last !== want.last) begin
				mismatches++;
				if (mismatches <= REPORT_MAX) begin
					$display("output word %0d differs (expected / actual):", words_seen);
					$display("  mixed_i %0d / %0d  mixed_q %0d / %0d",
						want.mixed_i, got.mixed_i, want.mixed_q, got.mixed_q);
					$display("  energy %0d / %0d  count %0d / %0d  last %0b / %0b",
						want.energy, got.energy, want.count, got.count, want.last, got.last);
				end
			end
		endfunction
	endclass

	logic          clk = 1'b0;
	logic          arst_n;
	logic          s_axis_tvalid;
	logic          s_axis_tready;
	logic [15:0]   s_axis_tdata;   // [7:0] i_sample, [15:8] q_sample
	logic          s_axis_tlast;   // block_last
	logic          m_axis_tvalid;
	logic          m_axis_tready = 1'b0;
	logic [103:0]  m_axis_tdata;   // [23:0] mixed_i, [47:24] mixed_q, [80:48] energy_sum,
	                               // [98:81] sample_count, [103:99] zero
	logic          m_axis_tlast;   // last_out
	logic          cfg_valid;
	logic          cfg_ready;
	logic [31:0]   cfg_data;       // phase_step

	mixer_scoreboard sb;
	bit steady = 1'b0;   // set: neither side idles

	nco_frequency_shift_mixer_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data)
	);

	always #2 clk = ~clk;

	// Output side: check each accepted word, then pick next cycle's ready.
	// Values read here are the ones from before the edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				sb.check_word(m_axis_tdata, m_axis_tlast);
			end
			m_axis_tready <= steady || ($urandom_range(99) >= 14);
		end
	end

	// One input word; random gaps ahead of it unless running steady.
	// valid stays high after the handshake so back-to-back words flow.
	task automatic send_sample(input nfsm_pkg::sample_t i, input nfsm_pkg::sample_t q,
			input logic last);
		while (!steady && $urandom_range(99) < 14) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {q, i};
		s_axis_tlast  <= last;
		do @(posedge clk); while (!s_axis_tready);
		sb.note_sample(i, q, last);
	endtask

	// Stop the input and wait for every owed word, plus a few spare cycles.
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (sb.pending() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE) @(posedge clk);
	endtask

	// Step register write, only once the pipeline is empty.
	task automatic write_step(input logic [31:0] value);
		drain();
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		sb.step = value;
	endtask

	// Random samples under one step setting; blocks end about one word in twelve.
	task automatic random_phase(input logic [31:0] value, input int words);
		write_step(value);
		repeat (words) begin
			send_sample(nfsm_pkg::sample_t'($urandom_range(255)),
				nfsm_pkg::sample_t'($urandom_range(255)), $urandom_range(11) == 0);
		end
	endtask

	initial begin
		sb = new();
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tlast  = 1'b0;
		cfg_valid     = 1'b0;
		cfg_data      = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// step from reset is zero: phase stays at 0, cos = 1
		send_sample(127, 0, 1'b0);
		send_sample(-128, -128, 1'b0);
		send_sample(0, 127, 1'b1);

		// quarter turn per sample walks the four quadrants
		write_step(32'h4000_0000);
		send_sample(127, 127, 1'b0);
		send_sample(-128, 127, 1'b0);
		send_sample(127, -128, 1'b0);
		send_sample(-128, -128, 1'b0);
		send_sample(1, -1, 1'b0);
		send_sample(0, 0, 1'b1);

		// half turn, most negative step
		write_step(32'h8000_0000);
		send_sample(-128, 0, 1'b0);
		send_sample(0, -128, 1'b0);
		send_sample(127, 127, 1'b1);

		// one table entry per sample
		write_step(32'h0040_0000);
		send_sample(127, -128, 1'b0);
		send_sample(-1, -1, 1'b0);
		send_sample(100, -100, 1'b1);

		// largest positive step, phase wraps every other sample
		write_step(32'h7FFF_FFFF);
		send_sample(127, 127, 1'b0);
		send_sample(-128, -128, 1'b0);
		send_sample(-128, 127, 1'b1);

		random_phase(32'h0000_0001, 140);
		random_phase(32'hFFFF_FFFF, 140);
		random_phase(32'h8000_0000, 140);
		random_phase(-($urandom_range(1, 40) << 22), 140);

		// block at full scale and full rate, no idling on either side
		steady = 1'b1;
		write_step($urandom());
		repeat (LONG_BLOCK) begin
			send_sample(-128, -128, 1'b0);
		end
		send_sample(-128, -128, 1'b1);
		drain();
		steady = 1'b0;

		random_phase($urandom(), 140);
		random_phase(32'h7FFF_FFFF, 140);
		random_phase($urandom_range(1, 1 << 20), 140);
		random_phase(32'h0000_0000, 140);

		drain();
		if (sb.mismatches == 0 && sb.pending() == 0) begin
			$display("nco_frequency_shift_mixer_unit: match");
		end else begin
			$display("nco_frequency_shift_mixer_unit: mismatch");
		end
		$finish;
	end

	// hang guard, far beyond the slowest legal run
	initial begin
		#20_000_000;
		$display("nco_frequency_shift_mixer_unit: mismatch");
		$finish;
	end

endmodule

/* filelist.f */
hw/rtl/nfsm_pkg.sv
hw/rtl/nfsm_phase.sv
hw/rtl/nfsm_sincos.sv
hw/rtl/nfsm_rotate.sv
hw/rtl/nfsm_accum.sv
hw/rtl/nco_frequency_shift_mixer_unit.sv
sim/testbench.sv
